>>> rtl/core/mked_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mked_pkg
// shared types and constants of the matrix keypad event detector
// ----------------------------------------------------------------------------
package mked_pkg;

  localparam int unsigned LevelBits = 6;
  localparam int unsigned KeyIdxW   = 3;
  localparam int unsigned DurW      = 32;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CfgAddrW  = 1;

  localparam logic [CfgW-1:0] LongPressDelayRst = 16'd2000;
  localparam logic [CfgW-1:0] RepeatIntervalRst = 16'd300;

  // register indexes
  localparam logic [CfgAddrW-1:0] CfgLongPressDelay = 1'b0;
  localparam logic [CfgAddrW-1:0] CfgRepeatInterval = 1'b1;

  // input commands
  localparam logic CmdTick = 1'b0;
  localparam logic CmdScan = 1'b1;

  // event kinds
  localparam logic KindPress   = 1'b0;
  localparam logic KindRelease = 1'b1;

  typedef struct packed {
    logic [KeyIdxW-1:0] key_index;
    logic               event_kind;
    logic               long_press;
    logic [DurW-1:0]    duration_ms;
    logic               last;
  } event_t;

  typedef struct packed {
    logic load;
    logic tick;
    logic visit;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic evt_found;
    logic key_last;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/mked_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mked_controller
// sequencer: accepts transactions, steps the key walk and flushes the last event
// ----------------------------------------------------------------------------
module mked_controller
  import mked_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_command_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFlush
  } state_e;

  state_e state_q;
  logic   accept;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = (state_q == StIdle);
    accept     = in_valid_i && in_ready_o;
    cmd_o.load = accept && (in_command_i == CmdScan);
    cmd_o.tick = accept && (in_command_i == CmdTick);
    unique case (state_q)
      StScan: begin
        cmd_o.visit = !(status_i.evt_found && status_i.pend_valid && !status_i.out_free);
      end
      StFlush: begin
        cmd_o.flush = status_i.pend_valid && status_i.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (cmd_o.load) state_q <= StScan;
        end
        StScan: begin
          if (cmd_o.visit && status_i.key_last) state_q <= StFlush;
        end
        StFlush: begin
          if (!status_i.pend_valid || status_i.out_free) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

>>> rtl/core/mked_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mked_datapath
// per-key state, time base, event evaluation, pending event and output register
// ----------------------------------------------------------------------------
module mked_datapath
  import mked_pkg::*;
#(
  parameter int unsigned NumKeys = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgAddrW-1:0]  cfg_addr_i,
  input  logic [CfgW-1:0]      cfg_wdata_i,
  input  logic [LevelBits-1:0] levels_i,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output event_t               out_event_o
);

  localparam int unsigned ActiveKeys = (NumKeys < LevelBits) ? NumKeys : LevelBits;
  localparam int unsigned KeyW       = (ActiveKeys > 1) ? $clog2(ActiveKeys) : 1;

  logic [CfgW-1:0]      delay_q;
  logic [CfgW-1:0]      interval_q;
  logic [DurW-1:0]      now_q;
  logic [LevelBits-1:0] levels_q;
  logic [KeyW-1:0]      key_q;
  logic [ActiveKeys-1:0] released_q;
  logic [DurW-1:0]      press_q  [ActiveKeys];
  logic [DurW-1:0]      repeat_q [ActiveKeys];
  event_t               pend_q;
  logic                 pend_valid_q;
  event_t               out_q;
  event_t               out_d;
  logic                 out_valid_q;

  logic            key_low;
  logic            sel_released;
  logic [DurW-1:0] elapsed_press;
  logic [DurW-1:0] elapsed_rep;
  logic            long_ok;
  logic            evt_press;
  logic            evt_long;
  logic            evt_release;
  logic            evt_found;
  logic            key_last;
  logic            out_free;
  logic            push;
  event_t          new_evt;

  always_comb begin
    key_low       = !levels_q[key_q];
    sel_released  = released_q[key_q];
    elapsed_press = now_q - press_q[key_q];
    elapsed_rep   = now_q - repeat_q[key_q];
    long_ok       = (elapsed_press > DurW'(delay_q)) && (elapsed_rep > DurW'(interval_q));
    evt_press     = key_low && sel_released;
    evt_long      = key_low && !sel_released && long_ok;
    evt_release   = !key_low && !sel_released;
    evt_found     = evt_press || evt_long || evt_release;
    key_last      = (key_q == KeyW'(ActiveKeys - 1));
    out_free      = !out_valid_q || out_ready_i;
    push          = (cmd_i.visit && evt_found && pend_valid_q) || cmd_i.flush;

    new_evt             = '0;
    new_evt.key_index   = KeyIdxW'(key_q);
    new_evt.event_kind  = evt_release ? KindRelease : KindPress;
    new_evt.long_press  = evt_long;
    new_evt.duration_ms = evt_press ? '0 : elapsed_press;

    out_d      = pend_q;
    out_d.last = cmd_i.flush;

    status_o.evt_found  = evt_found;
    status_o.key_last   = key_last;
    status_o.pend_valid = pend_valid_q;
    status_o.out_free   = out_free;
  end

  // configuration and time base
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= LongPressDelayRst;
      interval_q <= RepeatIntervalRst;
      now_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CfgLongPressDelay: delay_q    <= cfg_wdata_i;
          CfgRepeatInterval: interval_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.tick) now_q <= now_q + 1'b1;
    end
  end

  // key walk and per-key state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q   <= '1;
      key_q      <= '0;
      released_q <= '1;
      for (int i = 0; i < ActiveKeys; i++) begin
        press_q[i]  <= '0;
        repeat_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        levels_q <= levels_i;
        key_q    <= '0;
      end else if (cmd_i.visit) begin
        if (!key_last) key_q <= key_q + 1'b1;
        if (evt_press) begin
          released_q[key_q] <= 1'b0;
          press_q[key_q]    <= now_q;
        end
        if (evt_long) repeat_q[key_q] <= now_q;
        if (evt_release) begin
          released_q[key_q] <= 1'b1;
          press_q[key_q]    <= now_q;
        end
      end
    end
  end

  // pending event and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.visit && evt_found) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) out_q <= out_d;
    if (cmd_i.visit && evt_found) pend_q <= new_evt;
  end

  assign out_valid_o = out_valid_q;
  assign out_event_o = out_q;

endmodule

>>> rtl/core/matrix_keypad_event_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_event_detector
// press, long-press repeat and release events from matrix scan samples
// ----------------------------------------------------------------------------
// A tick transaction advances the millisecond counter. A scan transaction is
// walked through the decoded keys (at most six), one key per cycle unless the
// walk stalls while two events are waiting and the master side holds tready
// low. The last event of a scan is held back until the walk ends so that tlast
// can be set on it; a new transaction is taken once the walk has finished,
// even while the final event still sits in the output register.
module matrix_keypad_event_detector
  import mked_pkg::*;
#(
  parameter int unsigned NUM_COLUMNS = 3,
  parameter int unsigned NUM_ROWS    = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // key_levels
  input  logic                s_axis_tuser,   // command
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,   // key_index, duration_ms
  output logic [1:0]          m_axis_tuser,   // event_kind, long_press
  output logic                m_axis_tlast
);

  localparam int unsigned NumKeys = NUM_ROWS * NUM_COLUMNS;

  cmd_t    cmd;
  status_t status;
  event_t  out_event;

  mked_controller u_controller (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_command_i (s_axis_tuser),
    .in_ready_o   (s_axis_tready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  mked_datapath #(
    .NumKeys (NumKeys)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .levels_i    (s_axis_tdata[LevelBits-1:0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_event_o (out_event)
  );

  assign m_axis_tdata = {5'b0, out_event.duration_ms, out_event.key_index};
  assign m_axis_tuser = {out_event.long_press, out_event.event_kind};
  assign m_axis_tlast = out_event.last;

`ifndef NO_ASSERTIONS
  // nothing may be left pending when a new transaction can be taken
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !status.pend_valid)
    else $error("pending event left while idle");

  // a tick never starts a key walk
  a_tick_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == CmdTick)) |=> s_axis_tready)
    else $error("tick did not return to idle");

  // a long-press repeat is always a press event
  a_long_is_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tuser[0] == KindPress))
    else $error("long-press flag on a release");

  // a first press carries zero duration
  a_first_press_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[1] && (m_axis_tuser[0] == KindPress))
      |-> (m_axis_tdata[34:3] == '0))
    else $error("first press with non-zero duration");
`endif

endmodule

>>> tb/matrix_keypad_event_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_event_detector_tb
// self-checking bench for the keypad press, long-press and release detector
// ----------------------------------------------------------------------------
// Tick and scan transactions are fed from a queue, with random gaps on the
// slave side and random stalls on the master side. Each accepted transaction
// goes through a bench-side copy of the key tracking, which queues the
// events it should cause. Every event leaving the block is checked field by
// field against the oldest queued one. The delay and repeat registers are
// rewritten between phases while the block is idle, covering both extremes
// and a set of small values that make long-press repeats frequent.
// ----------------------------------------------------------------------------
module matrix_keypad_event_detector_tb;
  import mked_pkg::*;

  localparam int unsigned NumKeys      = 6;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned PhaseItems   = 62;

  typedef struct packed {
    logic                 cmd;
    logic [LevelBits-1:0] levels;
  } keypad_item_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [CfgW-1:0]     cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;   // key_levels
  logic                s_axis_tuser  = 1'b0; // command
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [39:0]         m_axis_tdata;         // key_index, duration_ms
  logic [1:0]          m_axis_tuser;         // event_kind, long_press
  logic                m_axis_tlast;

  matrix_keypad_event_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  keypad_item_t         keypad_samples_q[$];
  event_t               key_events_q[$];
  int unsigned          error_count = 0;
  int unsigned          cycle_count = 0;
  bit                   steady      = 1'b1;
  int unsigned          send_gap    = 0;
  int unsigned          recv_stall  = 0;
  logic [LevelBits-1:0] held_levels = '1;

  // key tracking state
  logic [CfgW-1:0] hold_delay;
  logic [CfgW-1:0] repeat_gap;
  logic [31:0]     clock_ms;
  logic            released [NumKeys];
  logic [31:0]     pressed_at [NumKeys];
  logic [31:0]     repeated_at [NumKeys];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    hold_delay = LongPressDelayRst;
    repeat_gap = RepeatIntervalRst;
    clock_ms   = '0;
    for (int k = 0; k < NumKeys; k++) begin
      released[k]    = 1'b1;
      pressed_at[k]  = '0;
      repeated_at[k] = '0;
    end
  end

  function automatic bit elapsed_over(logic [31:0] since, logic [31:0] lim);
    logic [31:0] diff;
    diff = clock_ms - since;
    return diff > lim;
  endfunction

  task automatic track_keys(input logic cmd, input logic [LevelBits-1:0] levels);
    event_t found[$];
    event_t ev;
    if (cmd == CmdTick) begin
      clock_ms = clock_ms + 32'd1;
      return;
    end
    for (int k = 0; k < NumKeys; k++) begin
      ev = '0;
      ev.key_index = k[KeyIdxW-1:0];
      if (!levels[k]) begin
        if (released[k]) begin
          ev.event_kind = KindPress;
          found.push_back(ev);
          released[k]   = 1'b0;
          pressed_at[k] = clock_ms;
        end else if (elapsed_over(pressed_at[k], {16'd0, hold_delay}) &&
                     elapsed_over(repeated_at[k], {16'd0, repeat_gap})) begin
          ev.event_kind  = KindPress;
          ev.long_press  = 1'b1;
          ev.duration_ms = clock_ms - pressed_at[k];
          found.push_back(ev);
          repeated_at[k] = clock_ms;
        end
      end else if (!released[k]) begin
        ev.event_kind  = KindRelease;
        ev.duration_ms = clock_ms - pressed_at[k];
        found.push_back(ev);
        pressed_at[k] = clock_ms;
        released[k]   = 1'b1;
      end
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) key_events_q.push_back(found[i]);
  endtask

  task automatic report_error(input string msg);
    error_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_event();
    event_t want;
    if (key_events_q.size() == 0) begin
      report_error($sformatf("unexpected event, tdata %0h tuser %0h", m_axis_tdata,
                             m_axis_tuser));
      return;
    end
    want = key_events_q.pop_front();
    if (m_axis_tdata[2:0] !== want.key_index)
      report_error($sformatf("key_index got %0d expected %0d", m_axis_tdata[2:0],
                             want.key_index));
    if (m_axis_tdata[34:3] !== want.duration_ms)
      report_error($sformatf("duration_ms key %0d got %0d expected %0d", want.key_index,
                             m_axis_tdata[34:3], want.duration_ms));
    if (m_axis_tdata[39:35] !== 5'd0)
      report_error($sformatf("tdata padding got %0h", m_axis_tdata[39:35]));
    if (m_axis_tuser[0] !== want.event_kind)
      report_error($sformatf("event_kind key %0d got %0b expected %0b", want.key_index,
                             m_axis_tuser[0], want.event_kind));
    if (m_axis_tuser[1] !== want.long_press)
      report_error($sformatf("long_press key %0d got %0b expected %0b", want.key_index,
                             m_axis_tuser[1], want.long_press));
    if (m_axis_tlast !== want.last)
      report_error($sformatf("last key %0d got %0b expected %0b", want.key_index,
                             m_axis_tlast, want.last));
  endtask

  // mostly short pauses, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        track_keys(s_axis_tuser, s_axis_tdata[LevelBits-1:0]);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (keypad_samples_q.size() > 0) begin
          keypad_item_t it;
          it = keypad_samples_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= it.cmd;
          s_axis_tdata  <= {2'b00, it.levels};
          send_gap = idle_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_event();
        recv_stall = idle_len();
      end else if (!m_axis_tvalid && $urandom_range(0, 9) == 0) begin
        recv_stall = idle_len();
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("matrix_keypad_event_detector_tb: done, errors");
      $finish;
    end
  end

  task automatic add_item(input logic cmd, input logic [LevelBits-1:0] levels);
    keypad_item_t it;
    it.cmd    = cmd;
    it.levels = levels;
    keypad_samples_q.push_back(it);
  endtask

  // key levels drift one bit at a time so that holds last, with some noise
  task automatic add_random_items(input int unsigned count);
    int unsigned r;
    repeat (count) begin
      if ($urandom_range(0, 99) < 45) begin
        add_item(CmdTick, LevelBits'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25) held_levels[$urandom_range(0, LevelBits-1)] ^= 1'b1;
        else if (r < 32) held_levels = LevelBits'($urandom);
        add_item(CmdScan, held_levels);
      end
    end
  endtask

  task automatic wait_idle();
    while (keypad_samples_q.size() != 0 || s_axis_tvalid || key_events_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    if (addr == CfgLongPressDelay) hold_delay = value;
    else repeat_gap = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [CfgW-1:0] delay, input logic [CfgW-1:0] gap,
                           input bit quiet);
    wait_idle();
    write_reg(CfgLongPressDelay, delay);
    write_reg(CfgRepeatInterval, gap);
    steady = quiet;
    add_random_items(PhaseItems);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset register values: presses, releases, single keys, alternating keys
    add_item(CmdScan, 6'b111111);
    add_item(CmdScan, 6'b000000);
    add_item(CmdTick, 6'b000000);
    add_item(CmdScan, 6'b000000);
    add_item(CmdScan, 6'b111110);
    add_item(CmdScan, 6'b011111);
    add_item(CmdScan, 6'b101010);
    add_item(CmdScan, 6'b010101);
    add_item(CmdTick, 6'b111111);
    add_item(CmdTick, 6'b101010);
    add_item(CmdScan, 6'b111111);
    add_item(CmdScan, 6'b111111);
    wait_idle();

    // zero delay and interval: repeats on every held tick, repeat time kept
    write_reg(CfgLongPressDelay, 16'd0);
    write_reg(CfgRepeatInterval, 16'd0);
    add_item(CmdScan, 6'b000000);
    add_item(CmdScan, 6'b000000);
    add_item(CmdTick, 6'b010101);
    add_item(CmdScan, 6'b000000);
    add_item(CmdTick, 6'b000000);
    add_item(CmdScan, 6'b000000);
    add_item(CmdScan, 6'b111111);
    add_item(CmdTick, 6'b111111);
    add_item(CmdScan, 6'b111110);
    add_item(CmdTick, 6'b000000);
    add_item(CmdScan, 6'b111110);
    steady = 1'b0;
    add_random_items(PhaseItems);

    run_phase(16'hffff, 16'hffff, 1'b0);
    run_phase(16'd1, 16'd0, 1'b1);
    run_phase(16'd0, 16'd3, 1'b0);
    run_phase(16'd5, 16'd2, 1'b0);
    run_phase(CfgW'($urandom_range(0, 8)), CfgW'($urandom_range(0, 6)), 1'b1);
    run_phase(16'd2000, 16'd300, 1'b0);
    wait_idle();

    if (error_count == 0) begin
      $display("matrix_keypad_event_detector_tb: done, clean");
    end else begin
      $display("matrix_keypad_event_detector_tb: done, errors");
    end
    $finish;
  end

endmodule
